[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define CHK_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that an antecedent is followed next cycle by a consequent
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/lkvc_pkg.sv]
package lkvc_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic search;
      logic update;
   } cmd_type;

endpackage

[rtl/lkvc_if.sv]
interface lkvc_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [lkvc_pkg::KEY_W-1:0] key;
   logic [lkvc_pkg::VAL_W-1:0] value;
   modport source (output valid, opcode, key, value, input ready);
   modport sink (input valid, opcode, key, value, output ready);
endinterface

interface lkvc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [lkvc_pkg::VAL_W-1:0] read_value;
   logic                       evicted;
   modport source (output valid, found, read_value, evicted, input ready);
   modport sink (input valid, found, read_value, evicted, output ready);
endinterface

interface lkvc_csr_if;
   logic                       valid;
   logic                       ready;
   logic [lkvc_pkg::CAP_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[rtl/lkvc_ctrl.sv]
`include "assert_macros.svh"

module lkvc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lkvc_pkg::cmd_type cmd
);

   lkvc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = lkvc_pkg::ST_SEARCH;
            end
         end
         lkvc_pkg::ST_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = lkvc_pkg::ST_UPDATE;
         end
         lkvc_pkg::ST_UPDATE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.update = 1'b1;
               state_in   = lkvc_pkg::ST_IDLE;
            end
         end
         default: state_in = lkvc_pkg::ST_IDLE;
      endcase
      rsp_valid_in = cmd.update || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   `CHK_NEXT(a_accept_search, clock, reset, req_valid && req_ready, state_ff == lkvc_pkg::ST_SEARCH)
   `CHK_NEXT(a_update_loads, clock, reset, cmd.update, rsp_valid_ff)

endmodule

[rtl/lkvc_datapath.sv]
`include "assert_macros.svh"

module lkvc_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lkvc_pkg::cmd_type          cmd,
   input  logic                       req_opcode,
   input  logic [lkvc_pkg::KEY_W-1:0] req_key,
   input  logic [lkvc_pkg::VAL_W-1:0] req_value,
   input  logic                       csr_write,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_data,
   output logic                       rsp_found,
   output logic [lkvc_pkg::VAL_W-1:0] rsp_read_value,
   output logic                       rsp_evicted
);

   localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   logic                       op_ff;
   logic [lkvc_pkg::KEY_W-1:0] key_ff;
   logic [lkvc_pkg::VAL_W-1:0] val_ff;

   logic [lkvc_pkg::KEY_W-1:0] cell_key_ff [DEPTH];
   logic [lkvc_pkg::VAL_W-1:0] cell_val_ff [DEPTH];
   logic [RW-1:0]              cell_rank_ff [DEPTH];
   logic [DEPTH-1:0]           valid_ff;
   logic [FW-1:0]              fill_ff;
   logic [lkvc_pkg::CAP_W-1:0] cap_ff;

   logic [DEPTH-1:0]           hit_ff, lru_ff, free_ff;
   logic                       found_ff, full_ff;
   logic [RW-1:0]              hit_rank_ff;
   logic [lkvc_pkg::VAL_W-1:0] hit_val_ff;

   logic                       out_found_ff, out_evicted_ff;
   logic [lkvc_pkg::VAL_W-1:0] out_val_ff;

   logic [DEPTH-1:0]           match, lru_vec, free_vec, tgt;
   logic [RW-1:0]              hit_rank, oldest;
   logic [lkvc_pkg::VAL_W-1:0] hit_val;
   logic                       full;
   logic                       set_miss;

   always_comb begin
      oldest = RW'(fill_ff - 1'b1);
      hit_rank = '0;
      hit_val  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         match[i]   = valid_ff[i] && (cell_key_ff[i] == key_ff);
         lru_vec[i] = valid_ff[i] && (cell_rank_ff[i] == oldest);
         hit_rank   = hit_rank | (cell_rank_ff[i] & {RW{match[i]}});
         hit_val    = hit_val | (cell_val_ff[i] & {lkvc_pkg::VAL_W{match[i]}});
      end
      // lowest free slot
      free_vec = ~valid_ff & (valid_ff + 1'b1);
      if (cap_ff == '0)
         full = (fill_ff != '0);
      else if (32'(cap_ff) > 32'(DEPTH))
         full = (32'(fill_ff) >= 32'(DEPTH));
      else
         full = (32'(fill_ff) >= 32'(cap_ff));
      set_miss = (op_ff == lkvc_pkg::OP_SET) && !found_ff;
      tgt      = full_ff ? lru_ff : free_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      if (cmd.search) begin
         hit_ff      <= match;
         found_ff    <= |match;
         hit_rank_ff <= hit_rank;
         hit_val_ff  <= hit_val;
         lru_ff      <= lru_vec;
         free_ff     <= free_vec;
         full_ff     <= full;
      end
      if (cmd.update) begin
         out_found_ff   <= found_ff;
         out_evicted_ff <= set_miss && full_ff;
         out_val_ff     <= (op_ff == lkvc_pkg::OP_GET && found_ff) ? hit_val_ff
                                                                   : lkvc_pkg::MISS_VALUE;
         for (int i = 0; i < DEPTH; i++) begin
            if (set_miss) begin
               if (tgt[i]) begin
                  cell_key_ff[i]  <= key_ff;
                  cell_val_ff[i]  <= val_ff;
                  cell_rank_ff[i] <= '0;
               end else if (valid_ff[i]) begin
                  cell_rank_ff[i] <= cell_rank_ff[i] + 1'b1;
               end
            end else if (found_ff) begin
               if (hit_ff[i]) begin
                  cell_rank_ff[i] <= '0;
                  if (op_ff == lkvc_pkg::OP_SET)
                     cell_val_ff[i] <= val_ff;
               end else if (valid_ff[i] && cell_rank_ff[i] < hit_rank_ff) begin
                  cell_rank_ff[i] <= cell_rank_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
         cap_ff   <= lkvc_pkg::CAP_RESET;
      end else begin
         if (csr_write)
            cap_ff <= csr_data;
         if (cmd.update && set_miss) begin
            valid_ff <= valid_ff | tgt;
            if (!full_ff)
               fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   assign rsp_found      = out_found_ff;
   assign rsp_read_value = out_val_ff;
   assign rsp_evicted    = out_evicted_ff;

   `CHK_PROP(a_keys_unique, clock, reset, $onehot0(match))
   `CHK_PROP(a_fill_tracks_valid, clock, reset, $countones(valid_ff) == 32'(fill_ff))

endmodule

[rtl/lru_key_value_cache.sv]
// Channel | Dir | Payload                               | Transfer
// req     | in  | opcode, key, value                    | valid && ready
// rsp     | out | found, read_value, evicted            | valid && ready
// csr     | in  | capacity (5 bits)                     | valid && ready
//
// Each request passes through accept, associative search over all
// DEPTH cells, then update of keys, values and recency ranks.
// The next request is accepted in the cycle after the update, while the
// result may still sit in the output register.
// A stalled result holds the update step until the output register frees.
// Reset is synchronous; all entries become invalid and capacity returns to 16.
module lru_key_value_cache #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   lkvc_req_if.sink   req_chan,
   lkvc_rsp_if.source rsp_chan,
   lkvc_csr_if.sink   csr_chan
);

   lkvc_pkg::cmd_type cmd;

   // configuration is always taken
   assign csr_chan.ready = 1'b1;

   // sequence each request through search and update
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // cell array, recency ranks and output register
   lkvc_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_chan.opcode),
      .req_key        (req_chan.key),
      .req_value      (req_chan.value),
      .csr_write      (csr_chan.valid),
      .csr_data       (csr_chan.data),
      .rsp_found      (rsp_chan.found),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_evicted    (rsp_chan.evicted)
   );

endmodule
